/* rtl/sbf_pkg.sv */
// Shared types, constants and register codes of the SBUS frame decoder.
package sbf_pkg;

    // Frame layout: header, 22 channel bytes, one flag byte, footer.
    localparam int PAYLOAD_BYTES   = 24;
    localparam int STORE_DEPTH     = PAYLOAD_BYTES - 1;
    localparam int FLAG_INDEX      = STORE_DEPTH - 1;
    localparam int NUM_CHANNELS    = 16;
    localparam int CHAN_W          = 11;
    localparam int CHAN_BITS       = NUM_CHANNELS * CHAN_W;
    localparam int POS_W           = 5;
    localparam int STORE_IDX_W     = $clog2(STORE_DEPTH);
    localparam int CHAN_IDX_W      = $clog2(NUM_CHANNELS);
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_NIBBLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FS_MASK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO    = 3'd5;

    // Register reset values.
    localparam logic [7:0]  RST_HEADER     = 8'h0F;
    localparam logic [7:0]  RST_FOOTER     = 8'h00;
    localparam logic [3:0]  RST_ALT_NIBBLE = 4'h4;
    localparam logic [7:0]  RST_LOST_MASK  = 8'h04;
    localparam logic [7:0]  RST_FS_MASK    = 8'h08;
    localparam logic [15:0] RST_IDLE_TMO   = 16'd7000;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [7:0]  footer_value;
        logic [3:0]  alt_footer_nibble;
        logic [7:0]  lost_frame_mask;
        logic [7:0]  failsafe_mask;
        logic [15:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic        failsafe;
        logic        lost_frame;
        logic [15:0] lost_count;
        logic        last;
    } out_item_t;

    // One good frame as it travels from the front end to the channel emitter.
    typedef struct packed {
        logic [CHAN_BITS-1:0] chan_bits;
        logic                 failsafe;
        logic                 lost_frame;
        logic [15:0]          lost_count;
    } frame_t;

endpackage

/* rtl/sbf_front.sv */
// Front end: idle timing, header hunt, payload capture and footer check.
module sbf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  sbf_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  sbf_pkg::in_item_t in_data,
    input  logic             q_full,
    output logic             q_push,
    output sbf_pkg::frame_t  q_frame
);
    import sbf_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [15:0]       idle_reg, idle_next;
    logic [15:0]       lost_cnt_reg, lost_cnt_next, lost_cnt_inc;
    logic [7:0]        store_reg [STORE_DEPTH];
    logic              store_we;
    logic [POS_W-1:0]  store_idx;
    logic              accept;
    logic              footer_ok;
    logic              lost_hit;

    // The only reason to stall is a full frame queue.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign pos_eff   = (idle_reg > cfg.idle_timeout) ? '0 : pos_reg;
    assign store_idx = pos_eff - POS_W'(1);
    assign footer_ok = (in_data.rx_byte == cfg.footer_value)
                    || (in_data.rx_byte[3:0] == cfg.alt_footer_nibble);
    assign lost_hit  = |(store_reg[FLAG_INDEX] & cfg.lost_frame_mask);
    assign lost_cnt_inc = lost_cnt_reg + 16'(lost_hit);

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS * CHAN_W / 8; i++)
        begin
            q_frame.chan_bits[8*i +: 8] = store_reg[i];
        end
        q_frame.failsafe   = |(store_reg[FLAG_INDEX] & cfg.failsafe_mask);
        q_frame.lost_frame = lost_hit;
        q_frame.lost_count = lost_cnt_inc;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        idle_next     = idle_reg;
        lost_cnt_next = lost_cnt_reg;
        store_we      = 1'b0;
        q_push        = 1'b0;
        if (accept)
        begin
            if (in_data.kind)
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 16'd1;
                end
            end
            else
            begin
                idle_next = '0;
                priority if (pos_eff == '0)
                begin
                    pos_next = (in_data.rx_byte == cfg.header_value) ? POS_W'(1) : '0;
                end
                else if (pos_eff < POS_W'(PAYLOAD_BYTES))
                begin
                    store_we = 1'b1;
                    pos_next = pos_eff + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                    if (footer_ok)
                    begin
                        q_push        = 1'b1;
                        lost_cnt_next = lost_cnt_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            idle_reg     <= '0;
            lost_cnt_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            idle_reg     <= idle_next;
            lost_cnt_reg <= lost_cnt_next;
        end
    end

    // Payload bytes need no reset; a frame is only released once all are written.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx[STORE_IDX_W-1:0]] <= in_data.rx_byte;
        end
    end

endmodule

/* rtl/sbf_queue.sv */
// Short frame queue between the front end and the channel emitter.
module sbf_queue #(
    parameter int DEPTH = sbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbf_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output sbf_pkg::frame_t pop_data,
    output logic            empty
);
    import sbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/sbf_back.sv */
// Channel emitter: unpacks one queued frame into sixteen channel results.
module sbf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  sbf_pkg::frame_t   q_frame,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output sbf_pkg::out_item_t out_data
);
    import sbf_pkg::*;

    logic                   busy_reg, busy_next;
    logic [CHAN_BITS-1:0]   bits_reg, bits_next;
    logic [CHAN_IDX_W-1:0]  idx_reg, idx_next;
    logic                   fs_reg, fs_next;
    logic                   lost_reg, lost_next;
    logic [15:0]            cnt_reg, cnt_next;
    logic                   ov_reg, ov_next;
    out_item_t              od_reg, od_next;
    logic                   load_out;
    logic                   at_last;

    assign load_out  = !ov_reg || out_ready;
    assign at_last   = (idx_reg == CHAN_IDX_W'(NUM_CHANNELS - 1));
    assign q_pop     = !q_empty && (!busy_reg || (load_out && at_last));
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        busy_next = busy_reg;
        bits_next = bits_reg;
        idx_next  = idx_reg;
        fs_next   = fs_reg;
        lost_next = lost_reg;
        cnt_next  = cnt_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        if (load_out)
        begin
            ov_next = busy_reg;
            if (busy_reg)
            begin
                od_next.channel_index = idx_reg;
                od_next.channel_value = bits_reg[CHAN_W-1:0];
                od_next.failsafe      = fs_reg;
                od_next.lost_frame    = lost_reg;
                od_next.lost_count    = cnt_reg;
                od_next.last          = at_last;
                bits_next = bits_reg >> CHAN_W;
                idx_next  = idx_reg + CHAN_IDX_W'(1);
                if (at_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        // A new frame is taken as the previous one hands over its final channel.
        if (q_pop)
        begin
            busy_next = 1'b1;
            bits_next = q_frame.chan_bits;
            idx_next  = '0;
            fs_next   = q_frame.failsafe;
            lost_next = q_frame.lost_frame;
            cnt_next  = q_frame.lost_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        fs_reg   <= fs_next;
        lost_reg <= lost_next;
        cnt_reg  <= cnt_next;
        od_reg   <= od_next;
    end

endmodule

/* rtl/sbus_frame_decoder.sv */
// Top level of the SBUS frame decoder: register file, front end, queue and emitter.
//
// The input channel (in_valid, in_ready, in_data) carries one transaction per
// received byte or per one-microsecond tick. The decoder hunts for the header
// byte, captures 22 channel bytes and one flag byte, and checks the footer.
// A good frame produces sixteen transactions on the output channel (out_valid,
// out_ready, out_data), channel 0 through 15, the last one marked by "last".
// A bad footer produces nothing. Silence longer than idle_timeout ticks before
// a byte restarts the header hunt.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// one register per transaction and is always ready; indexes beyond the register
// list are ignored. Write it only while the decoder is idle.
// Throughput: one input transaction per cycle while in_ready is high. The front
// end hands a finished frame to a frame queue (QUEUE_DEPTH, two by default), so
// it keeps taking bytes while the emitter drains the previous frame at one
// channel per cycle while out_ready is high. A frame passes through the queue
// and the emitter's output register. in_ready drops only while the queue is full,
// which takes a stalled receiver and more than QUEUE_DEPTH completed frames waiting.
// Reset clears the registers to their defaults, the hunt state, the idle timer,
// the lost-frame counter and all queued frames. The payload bytes are not reset.
module sbus_frame_decoder #(
    parameter int QUEUE_DEPTH = sbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sbf_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sbf_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sbf_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   q_push, q_pop, q_full, q_empty;
    frame_t q_in, q_out;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER:     cfg_next.header_value      = cfg_data[7:0];
                REG_FOOTER:     cfg_next.footer_value      = cfg_data[7:0];
                REG_ALT_NIBBLE: cfg_next.alt_footer_nibble = cfg_data[3:0];
                REG_LOST_MASK:  cfg_next.lost_frame_mask   = cfg_data[7:0];
                REG_FS_MASK:    cfg_next.failsafe_mask     = cfg_data[7:0];
                REG_IDLE_TMO:   cfg_next.idle_timeout      = cfg_data[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value      <= RST_HEADER;
            cfg_reg.footer_value      <= RST_FOOTER;
            cfg_reg.alt_footer_nibble <= RST_ALT_NIBBLE;
            cfg_reg.lost_frame_mask   <= RST_LOST_MASK;
            cfg_reg.failsafe_mask     <= RST_FS_MASK;
            cfg_reg.idle_timeout      <= RST_IDLE_TMO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_frame  (q_in)
    );

    sbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_frame   (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A finished frame must never meet a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("frame pushed into a full queue");

    // Within a frame, channels come out in strict order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last) |=>
        (!out_valid || out_data.channel_index ==
            CHAN_IDX_W'($past(out_data.channel_index) + CHAN_IDX_W'(1))))
        else $error("channel results out of order");

    // The last flag belongs to the final channel only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.channel_index ==
            CHAN_IDX_W'(NUM_CHANNELS - 1))))
        else $error("last flag on the wrong channel");

endmodule
